### rtl/life_grid_engine_defines.svh
// Assertion macros shared by the life grid engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LIFE_GRID_ENGINE_DEFINES_SVH
`define LIFE_GRID_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LGE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lge_pkg.sv
// Shared types and constants for the life grid engine.
// No dependencies; used by every module of the block.
package lge_pkg;

    // default geometry limits
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // fixed field widths
    localparam int CMD_W      = 8;
    localparam int GEOM_W     = 7;
    localparam int GEN_W      = 16;
    localparam int ROW_IDX_W  = 6;
    localparam int CELLS_W    = 64;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // draw commands (ASCII)
    localparam logic [CMD_W-1:0] CMD_UP    = 8'h77; // w
    localparam logic [CMD_W-1:0] CMD_LEFT  = 8'h61; // a
    localparam logic [CMD_W-1:0] CMD_DOWN  = 8'h73; // s
    localparam logic [CMD_W-1:0] CMD_RIGHT = 8'h64; // d
    localparam logic [CMD_W-1:0] CMD_PEN   = 8'h78; // x

    // Life rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // register word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GEN_COUNT   = 2'd2
    } cfg_reg_t;

    // grid store control from the sequencer
    typedef struct packed {
        logic                 rd_en;
        logic [ROW_IDX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_addr;
        logic                 clr_en;    // drop rows at or above keep_rows
        logic [GEOM_W-1:0]    keep_rows;
    } mem_ctrl_t;

endpackage

### rtl/lge_grid_mem.sv
// Grid store: one word per row, one write and one registered read port.
// Per-row valid flops give the all-dead reset. Depends on lge_pkg.
module lge_grid_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lge_pkg::mem_ctrl_t ctrl,
    input  logic [COLS-1:0]    wr_data,
    output logic [COLS-1:0]    rd_data
);
    import lge_pkg::*;

    localparam int AW = $clog2(ROWS);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_q_reg;
    logic            rd_valid_reg;
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;

    // row storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr[AW-1:0]] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_q_reg <= mem[ctrl.rd_addr[AW-1:0]];
        end
    end

    // valid bits: set on write, dropped above the active height
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ROWS; i++)
        begin
            if (ctrl.wr_en && (ctrl.wr_addr[AW-1:0] == AW'(i)))
            begin
                valid_next[i] = 1'b1;
            end
            if (ctrl.clr_en && (GEOM_W'(i) >= ctrl.keep_rows))
            begin
                valid_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr[AW-1:0]];
            end
        end
    end

    // a never-written row reads as dead
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

### rtl/lge_row_rule.sv
// Row update unit: neighbour count and birth/survival rule for one row.
// Shared by every row of every generation. Depends on lge_pkg.
module lge_row_rule #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] up_row,
    input  logic [COLS-1:0] mid_row,
    input  logic [COLS-1:0] dn_row,
    input  logic [COLS-1:0] col_mask,
    output logic [COLS-1:0] next_row
);
    import lge_pkg::*;

    logic [COLS+1:0] up_p;
    logic [COLS+1:0] mid_p;
    logic [COLS+1:0] dn_p;
    logic [3:0]      cnt;

    // zero guard column on each side; column c sees pad bits c..c+2
    always_comb
    begin
        up_p  = {1'b0, up_row, 1'b0};
        mid_p = {1'b0, mid_row, 1'b0};
        dn_p  = {1'b0, dn_row, 1'b0};
        cnt   = '0;
        for (int c = 0; c < COLS; c++)
        begin
            cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                + 4'(mid_p[c]) + 4'(mid_p[c+2])
                + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
            next_row[c] = col_mask[c]
                && ((cnt == BIRTH_COUNT) || (mid_row[c] && (cnt == SURVIVE_COUNT)));
        end
    end

endmodule

### rtl/life_grid_engine.sv
// Life grid engine. A draw word (tuser=0) moves the cursor or toggles the pen;
// with the pen down it also does a read-modify-write of the cursor row. A run
// word (tuser=1) computes G generations, then streams H rows to the sink,
// where G is generation_count and H the active height; during compute the
// single read port of the grid store is swept one row per cycle by the
// shared row update unit. s_tready is low until the word is finished.
// The grid is dead right after reset: no clearing pass is needed.
// Depends on lge_pkg, lge_grid_mem, lge_row_rule and the defines header.
`include "life_grid_engine_defines.svh"

module life_grid_engine #(
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lge_pkg::CMD_W-1:0]        s_tdata,  // [7:0] command_byte
    input  logic                             s_tuser,  // [0] mode
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lge_pkg::OUT_DATA_W-1:0]   m_tdata,  // [5:0] row_index, [69:6] row_cells
    output logic                             m_tlast,  // last_row
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lge_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lge_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lge_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lge_pkg::*;

    localparam int ROW_CAP = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(ROW_CAP);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_GEN_START,
        ST_GEN_PRIME,
        ST_GEN_ROW,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } state_t;

    // registers
    logic [GEOM_W-1:0]   grid_width_reg;
    logic [GEOM_W-1:0]   grid_height_reg;
    logic [GEN_W-1:0]    gen_count_reg;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]    cursor_row_reg, cursor_row_next;
    logic                pen_down_reg, pen_down_next;
    logic [GEN_W-1:0]    gen_left_reg, gen_left_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [ROW_W-1:0]    ey_reg, ey_next;
    logic [MAX_COLS-1:0] up_reg, up_next;
    logic [MAX_COLS-1:0] mid_reg, mid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [MAX_COLS-1:0] out_cells_reg, out_cells_next;
    logic                out_last_reg, out_last_next;

    // datapath
    logic [GEOM_W-1:0]   act_w;
    logic [GEOM_W-1:0]   act_h;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] wr_data;
    logic [MAX_COLS-1:0] dn_row;
    logic [MAX_COLS-1:0] rule_row;
    logic [MAX_COLS-1:0] pen_bit;
    logic [GEOM_W-1:0]   x_move;
    logic [GEOM_W-1:0]   y_move;
    logic                in_accept;
    mem_ctrl_t           mem_ctrl;

    // register port: write in the access phase, read any time
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            gen_count_reg   <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GEOM_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[GEOM_W-1:0];
                REG_GEN_COUNT:   gen_count_reg   <= pwdata[GEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            REG_GEN_COUNT:   prdata = APB_DATA_W'(gen_count_reg);
            default:         prdata = '0;
        endcase
    end

    // active geometry: zero reads as one, larger values clamped to the storage
    always_comb
    begin
        if (grid_width_reg == '0)
            act_w = GEOM_W'(1);
        else if (grid_width_reg > GEOM_W'(MAX_COLS))
            act_w = GEOM_W'(MAX_COLS);
        else
            act_w = grid_width_reg;

        if (grid_height_reg == '0)
            act_h = GEOM_W'(1);
        else if (grid_height_reg > GEOM_W'(ROW_CAP))
            act_h = GEOM_W'(ROW_CAP);
        else
            act_h = grid_height_reg;

        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (GEOM_W'(c) < act_w);
        end
    end

    // grid store and row update unit
    lge_grid_mem #(
        .ROWS (ROW_CAP),
        .COLS (MAX_COLS)
    ) u_grid_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign dn_row = ((GEOM_W'(y_reg) + GEOM_W'(1)) < act_h) ? (rd_data & col_mask) : '0;

    lge_row_rule #(
        .COLS (MAX_COLS)
    ) u_row_rule (
        .up_row   (up_reg),
        .mid_row  (mid_reg),
        .dn_row   (dn_row),
        .col_mask (col_mask),
        .next_row (rule_row)
    );

    assign pen_bit   = MAX_COLS'(1) << cursor_col_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        pen_down_next   = pen_down_reg;
        gen_left_next   = gen_left_reg;
        y_next          = y_reg;
        ey_next         = ey_reg;
        up_next         = up_reg;
        mid_next        = mid_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_row_next    = out_row_reg;
        out_cells_next  = out_cells_reg;
        out_last_next   = out_last_reg;
        mem_ctrl        = '0;
        wr_data         = '0;
        x_move          = GEOM_W'(cursor_col_reg);
        y_move          = GEOM_W'(cursor_row_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!s_tuser)
                    begin
                        // move, then clamp to the active grid
                        if ((s_tdata == CMD_LEFT) && (x_move != '0))
                            x_move = x_move - GEOM_W'(1);
                        if (s_tdata == CMD_RIGHT)
                            x_move = x_move + GEOM_W'(1);
                        if ((s_tdata == CMD_UP) && (y_move != '0))
                            y_move = y_move - GEOM_W'(1);
                        if (s_tdata == CMD_DOWN)
                            y_move = y_move + GEOM_W'(1);
                        if (x_move >= act_w)
                            x_move = act_w - GEOM_W'(1);
                        if (y_move >= act_h)
                            y_move = act_h - GEOM_W'(1);
                        cursor_col_next = x_move[COL_W-1:0];
                        cursor_row_next = y_move[ROW_W-1:0];
                        pen_down_next   = (s_tdata == CMD_PEN) ? !pen_down_reg
                                                               : pen_down_reg;
                        if (pen_down_next)
                            state_next = ST_DRAW_RD;
                    end
                    else if (gen_count_reg == '0)
                    begin
                        ey_next    = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        gen_left_next = gen_count_reg;
                        state_next    = ST_GEN_START;
                    end
                end
            end

            ST_DRAW_RD:
            begin
                mem_ctrl.rd_en   = 1'b1;
                mem_ctrl.rd_addr = ROW_IDX_W'(cursor_row_reg);
                state_next       = ST_DRAW_WR;
            end

            ST_DRAW_WR:
            begin
                mem_ctrl.wr_en   = 1'b1;
                mem_ctrl.wr_addr = ROW_IDX_W'(cursor_row_reg);
                wr_data          = rd_data | pen_bit;
                state_next       = ST_IDLE;
            end

            // generation: row window up/mid in flops, dn from the read port
            ST_GEN_START:
            begin
                mem_ctrl.rd_en   = 1'b1;
                mem_ctrl.rd_addr = '0;
                up_next          = '0;
                state_next       = ST_GEN_PRIME;
            end

            ST_GEN_PRIME:
            begin
                mid_next = rd_data & col_mask;
                if (act_h > GEOM_W'(1))
                begin
                    mem_ctrl.rd_en   = 1'b1;
                    mem_ctrl.rd_addr = ROW_IDX_W'(1);
                end
                y_next     = '0;
                state_next = ST_GEN_ROW;
            end

            ST_GEN_ROW:
            begin
                // new row is written in place; old row lives on in up_reg
                mem_ctrl.wr_en   = 1'b1;
                mem_ctrl.wr_addr = ROW_IDX_W'(y_reg);
                wr_data          = rule_row;
                up_next          = mid_reg;
                mid_next         = dn_row;
                if ((GEOM_W'(y_reg) + GEOM_W'(2)) < act_h)
                begin
                    mem_ctrl.rd_en   = 1'b1;
                    mem_ctrl.rd_addr = ROW_IDX_W'(GEOM_W'(y_reg) + GEOM_W'(2));
                end
                if ((GEOM_W'(y_reg) + GEOM_W'(1)) == act_h)
                begin
                    mem_ctrl.clr_en    = 1'b1;
                    mem_ctrl.keep_rows = act_h;
                    gen_left_next      = gen_left_reg - GEN_W'(1);
                    if (gen_left_reg == GEN_W'(1))
                    begin
                        ey_next    = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_GEN_START;
                    end
                end
                else
                begin
                    y_next = y_reg + ROW_W'(1);
                end
            end

            ST_EMIT_RD:
            begin
                mem_ctrl.rd_en   = 1'b1;
                mem_ctrl.rd_addr = ROW_IDX_W'(ey_reg);
                state_next       = ST_EMIT_LOAD;
            end

            ST_EMIT_LOAD:
            begin
                out_row_next   = ey_reg;
                out_cells_next = rd_data & col_mask;
                out_last_next  = ((GEOM_W'(ey_reg) + GEOM_W'(1)) == act_h);
                m_tvalid_next  = 1'b1;
                state_next     = ST_EMIT_HOLD;
            end

            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ey_next          = ey_reg + ROW_W'(1);
                        mem_ctrl.rd_en   = 1'b1;
                        mem_ctrl.rd_addr = ROW_IDX_W'(ey_reg + ROW_W'(1));
                        state_next       = ST_EMIT_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            pen_down_reg   <= 1'b0;
            gen_left_reg   <= '0;
            y_reg          <= '0;
            ey_reg         <= '0;
            up_reg         <= '0;
            mid_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            out_row_reg    <= '0;
            out_cells_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            pen_down_reg   <= pen_down_next;
            gen_left_reg   <= gen_left_next;
            y_reg          <= y_next;
            ey_reg         <= ey_next;
            up_reg         <= up_next;
            mid_reg        <= mid_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_row_reg    <= out_row_next;
            out_cells_reg  <= out_cells_next;
            out_last_reg   <= out_last_next;
        end
    end

    // output word
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - ROW_IDX_W - CELLS_W){1'b0}},
                       CELLS_W'(out_cells_reg), ROW_IDX_W'(out_row_reg)};

    // checks
    `LGE_ASSERT_IMPLY(a_valid_in_hold, clk, rst_n, m_tvalid_reg,
        state_reg == ST_EMIT_HOLD, "output word valid outside the hold state")
    `LGE_ASSERT_NEXT(a_load_shows_word, clk, rst_n, state_reg == ST_EMIT_LOAD,
        m_tvalid_reg, "loaded row not presented")
    `LGE_ASSERT_IMPLY(a_sweep_no_overlap, clk, rst_n,
        (state_reg == ST_GEN_ROW) && mem_ctrl.rd_en,
        mem_ctrl.rd_addr != mem_ctrl.wr_addr, "sweep reads the row it writes")
    `LGE_ASSERT_IMPLY(a_gen_left_live, clk, rst_n,
        (state_reg == ST_GEN_START) || (state_reg == ST_GEN_PRIME) ||
        (state_reg == ST_GEN_ROW), gen_left_reg != '0, "generation run with none left")

endmodule
